// ===== rtl/rrfsa_pkg.sv =====
package rrfsa_pkg;

    localparam int MaskW       = 32;
    localparam int IdxW        = 5;
    localparam int CfgIdxW     = 3;
    localparam int DefNumSlots = 32;

    typedef logic [1:0]         t_action;
    typedef logic [IdxW-1:0]    t_idx;
    typedef logic [MaskW-1:0]   t_mask;
    typedef logic [CfgIdxW-1:0] t_cfg_idx;

    // request codes
    localparam t_action ACT_RESTART = 2'd0;
    localparam t_action ACT_FIXED   = 2'd1;
    localparam t_action ACT_FLOAT   = 2'd2;

    // configuration register indexes
    localparam t_cfg_idx REG_FIXED_FIRST   = 3'd0;
    localparam t_cfg_idx REG_FIXED_LAST    = 3'd1;
    localparam t_cfg_idx REG_FIXED_RESTART = 3'd2;
    localparam t_cfg_idx REG_FLOAT_FIRST   = 3'd3;
    localparam t_cfg_idx REG_FLOAT_LAST    = 3'd4;
    localparam t_cfg_idx REG_FLOAT_RESTART = 3'd5;

    // reset values
    localparam t_idx RST_FIXED_FIRST   = 5'd0;
    localparam t_idx RST_FIXED_LAST    = 5'd31;
    localparam t_idx RST_FIXED_RESTART = 5'd11;
    localparam t_idx RST_FLOAT_FIRST   = 5'd0;
    localparam t_idx RST_FLOAT_LAST    = 5'd31;
    localparam t_idx RST_FLOAT_RESTART = 5'd1;

    typedef struct packed {
        logic found;
        t_idx idx;
    } t_hit;

    // circular window a..b; wraps through the top of the vector when a > b
    function automatic t_mask range_mask(t_idx a, t_idx b);
        t_mask up_a;
        t_mask up_to_b;
        up_a    = {MaskW{1'b1}} << a;
        up_to_b = ~({{(MaskW-1){1'b1}}, 1'b0} << b);
        return (a <= b) ? (up_a & up_to_b) : (up_a | up_to_b);
    endfunction

    // lowest set bit
    function automatic t_hit lowest(t_mask v);
        t_hit h;
        h = '0;
        for (int i = MaskW - 1; i >= 0; i--) begin
            if (v[i]) begin
                h.found = 1'b1;
                h.idx   = IdxW'(i);
            end
        end
        return h;
    endfunction

    // first set bit of free & seg in circular order starting at start
    function automatic t_hit find_free(t_mask free, t_idx start, t_mask seg);
        t_mask upper;
        t_hit  h_hi;
        t_hit  h_lo;
        upper = {MaskW{1'b1}} << start;
        h_hi  = lowest(free & seg & upper);
        h_lo  = lowest(free & seg & ~upper);
        return h_hi.found ? h_hi : h_lo;
    endfunction

endpackage

// ===== rtl/round_robin_free_slot_allocator.sv =====
// Round-robin free slot allocator, two pools (fixed, float).
// A transaction is captured in the input stage registers, then its result is
// registered in the result stage; an output stall can hold it in either.
// Throughput: one transaction per cycle unless the output stalls; the search is a
// pair of rotated priority encoders over the 32-bit mask, the pointer is the only loop.
// Reset (i_rst_n low, synchronous): pipeline empty, config and pointers to defaults.
module round_robin_free_slot_allocator
    import rrfsa_pkg::*;
#(
    parameter int NUM_SLOTS = DefNumSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_busy_mask,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_slot,
    output logic        o_granted,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    // slots at or above the limit never grant
    localparam int SlotLimit = (NUM_SLOTS < MaskW) ? NUM_SLOTS : MaskW;
    localparam logic [IdxW:0] LimitW = (IdxW+1)'(SlotLimit);
    localparam t_mask SlotOkMask = MaskW'((64'd1 << SlotLimit) - 64'd1);

    // configuration
    t_idx r_fixed_first, r_fixed_last, r_fixed_restart;
    t_idx r_float_first, r_float_last, r_float_restart;

    // pool pointers
    t_idx r_fixed_ptr, r_float_ptr;
    t_idx n_fixed_ptr, n_float_ptr;

    // input stage
    logic    r_in_valid;
    t_action r_action;
    t_mask   r_mask;

    // result stage
    logic r_out_valid;
    t_idx r_slot;
    logic r_granted;

    logic advance;   // input stage moves into the result stage
    logic fire;      // a transaction is processed this cycle

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fixed_first   <= RST_FIXED_FIRST;
            r_fixed_last    <= RST_FIXED_LAST;
            r_fixed_restart <= RST_FIXED_RESTART;
            r_float_first   <= RST_FLOAT_FIRST;
            r_float_last    <= RST_FLOAT_LAST;
            r_float_restart <= RST_FLOAT_RESTART;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FIXED_FIRST:   r_fixed_first   <= i_cfg_data;
                REG_FIXED_LAST:    r_fixed_last    <= i_cfg_data;
                REG_FIXED_RESTART: r_fixed_restart <= i_cfg_data;
                REG_FLOAT_FIRST:   r_float_first   <= i_cfg_data;
                REG_FLOAT_LAST:    r_float_last    <= i_cfg_data;
                REG_FLOAT_RESTART: r_float_restart <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // -------------------------------------------------------------------
    // Search. The walk from pointer s runs s, s+1, ... (mod limit) until it
    // lands on last, then restarts at first and runs up to last again.
    // Phase 1 covers s..last; phase 2 covers first..last. When last is
    // beyond the limit it is never reached (unless s is last itself), so
    // the walk just circles the whole ring.
    // -------------------------------------------------------------------
    logic  is_fixed, is_alloc;
    t_idx  sel_first, sel_last, sel_ptr;
    t_mask free;
    logic  last_in, ptr_in, first_in, p2_en;
    t_idx  start1, start2;
    t_mask seg1, seg2;
    t_hit  hit1, hit2, hit;
    t_idx  nxt;
    logic  grant;

    always_comb begin
        is_fixed  = (r_action == ACT_FIXED);
        is_alloc  = (r_action == ACT_FIXED) || (r_action == ACT_FLOAT);
        sel_first = is_fixed ? r_fixed_first : r_float_first;
        sel_last  = is_fixed ? r_fixed_last  : r_float_last;
        sel_ptr   = is_fixed ? r_fixed_ptr   : r_float_ptr;

        free     = ~r_mask & SlotOkMask;
        last_in  = {1'b0, sel_last}  < LimitW;
        ptr_in   = {1'b0, sel_ptr}   < LimitW;
        first_in = {1'b0, sel_first} < LimitW;

        // an out-of-range position steps straight to 0
        start1 = ptr_in   ? sel_ptr   : '0;
        start2 = first_in ? sel_first : '0;

        if (last_in) begin
            seg1 = range_mask(start1, sel_last);
        end else if (sel_ptr == sel_last) begin
            seg1 = '0;
        end else begin
            seg1 = '1;
        end

        p2_en = last_in || (sel_ptr == sel_last);
        if (!p2_en) begin
            seg2 = '0;
        end else if (last_in) begin
            seg2 = range_mask(start2, sel_last);
        end else if (sel_first == sel_last) begin
            seg2 = '0;
        end else begin
            seg2 = '1;
        end

        hit1 = find_free(free, start1, seg1);
        hit2 = find_free(free, start2, seg2);
        hit  = hit1.found ? hit1 : hit2;

        // pointer moves one past the granted slot; past last it goes to first, past the limit to 0
        if (hit.idx == sel_last) begin
            nxt = sel_first;
        end else if (({1'b0, hit.idx} + (IdxW+1)'(1)) >= LimitW) begin
            nxt = '0;
        end else begin
            nxt = hit.idx + t_idx'(1);
        end

        grant = is_alloc && hit.found;

        n_fixed_ptr = r_fixed_ptr;
        n_float_ptr = r_float_ptr;
        case (r_action)
            ACT_RESTART: begin
                n_fixed_ptr = r_fixed_restart;
                n_float_ptr = r_float_restart;
            end
            ACT_FIXED: if (hit.found) n_fixed_ptr = nxt;
            ACT_FLOAT: if (hit.found) n_float_ptr = nxt;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fixed_ptr <= RST_FIXED_RESTART;
            r_float_ptr <= RST_FLOAT_RESTART;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_fixed_ptr <= n_fixed_ptr;
                r_float_ptr <= n_float_ptr;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_action <= i_action;
            r_mask   <= i_busy_mask;
        end
        if (fire) begin
            r_slot    <= grant ? hit.idx : '0;
            r_granted <= grant;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_slot      = r_slot;
    assign o_granted   = r_granted;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rrfsa_pkg::*;

    // Action code that the block must ignore (no package name exists for it)
    localparam t_action ACT_UNUSED = 2'd3;

    // Register indexes past the last real register; writes there are dropped
    localparam t_cfg_idx REG_SPARE_LO = 3'd6;
    localparam t_cfg_idx REG_SPARE_HI = 3'd7;

    localparam int POOL_FIXED = 0;
    localparam int POOL_FLOAT = 1;

    // Idle / stall rates, percent of cycles
    localparam int RATE_NONE  = 0;
    localparam int RATE_HEAVY = 85;
    localparam int RATE_BOTH  = 24;

    localparam int HOLD_CYCLES = 80;
    localparam int NUM_ROWS    = 20;

    // Per-pool wrap range, restart value and next-candidate pointer
    typedef struct packed {
        t_idx first;
        t_idx last;
        t_idx restart;
        t_idx ptr;
    } t_pool;

    // One search outcome
    typedef struct packed {
        logic granted;
        t_idx slot;
        t_idx next_ptr;
    } t_scan;

    // One result transaction as seen on the output
    typedef struct packed {
        t_idx slot;
        logic granted;
    } t_grant;

    // Directed stimulus row; typed = 1 means the expected result is given
    typedef struct packed {
        t_action act;
        t_mask   busy;
        logic    typed;
        t_idx    slot;
        logic    granted;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_action;
    logic [31:0] i_busy_mask;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [4:0]  o_slot;
    logic        o_granted;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;

    t_pool  pools [2];
    t_grant grants_due [$];
    t_row   directed_rows [NUM_ROWS];

    int  mismatches;
    int  n_checked;
    int  n_grants;
    int  n_refusals;
    int  n_restarts;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    bit  hold_req;

    round_robin_free_slot_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_busy_mask (i_busy_mask),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_slot      (o_slot),
        .o_granted   (o_granted),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake locks up
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Slot search: walk from start, wrapping last -> first (and 31 -> 0),
    // stop at the first clear busy bit. Give up when the walk returns to
    // start or after 32 visits; that bound also covers a pointer outside
    // first..last and first > last.
    // ------------------------------------------------------------------
    function automatic t_scan scan_pool(t_idx start, t_idx first, t_idx last, t_mask busy);
        t_scan s;
        t_idx  p;
        t_idx  n;
        bit    done;
        s = '0;
        s.next_ptr = start;
        p = start;
        done = 1'b0;
        for (int v = 0; v < MaskW && !done; v++) begin
            n = (p == last) ? first : t_idx'(p + 1'b1);
            if (!busy[p]) begin
                s.granted  = 1'b1;
                s.slot     = p;
                s.next_ptr = n;
                done       = 1'b1;
            end else if (n == start) begin
                done = 1'b1;
            end else begin
                p = n;
            end
        end
        return s;
    endfunction

    // Result of one request; moves the pool pointers like the block does
    function automatic t_grant predict_grant(t_action act, t_mask busy);
        t_grant r;
        t_scan  s;
        int     k;
        r = '0;
        case (act)
            ACT_RESTART: begin
                pools[POOL_FIXED].ptr = pools[POOL_FIXED].restart;
                pools[POOL_FLOAT].ptr = pools[POOL_FLOAT].restart;
            end
            ACT_FIXED, ACT_FLOAT: begin
                k = (act == ACT_FIXED) ? POOL_FIXED : POOL_FLOAT;
                s = scan_pool(pools[k].ptr, pools[k].first, pools[k].last, busy);
                if (s.granted) pools[k].ptr = s.next_ptr;
                r.slot    = s.slot;
                r.granted = s.granted;
            end
            default: ;  // unused code: no state change, empty result
        endcase
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request side. Called right after a falling edge. Optional idle gap,
    // then the transaction is held until a rising edge sees stall low.
    // Valid is left high on return so back-to-back items never toggle it.
    // ------------------------------------------------------------------
    task automatic send_request(t_action act, t_mask busy, logic typed, t_idx want_slot,
                                logic want_granted);
        t_grant g;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_action    = act;
        i_busy_mask = busy;
        do @(posedge i_clk); while (o_in_stall);
        // accepted at this edge: advance the predictor in acceptance order
        g = predict_grant(act, busy);
        if (typed) begin
            g.slot    = want_slot;
            g.granted = want_granted;
        end
        grants_due.push_back(g);
        if (act == ACT_RESTART) n_restarts++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result, plus a margin.
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (grants_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write all six registers back to back while idle; the spare indexes
    // get junk and must change nothing. Pointers are not touched by writes.
    task automatic load_setting(t_idx fx_first, t_idx fx_last, t_idx fx_restart,
                                t_idx fl_first, t_idx fl_last, t_idx fl_restart);
        t_idx vals [8];
        vals[REG_FIXED_FIRST]   = fx_first;
        vals[REG_FIXED_LAST]    = fx_last;
        vals[REG_FIXED_RESTART] = fx_restart;
        vals[REG_FLOAT_FIRST]   = fl_first;
        vals[REG_FLOAT_LAST]    = fl_last;
        vals[REG_FLOAT_RESTART] = fl_restart;
        vals[REG_SPARE_LO]      = t_idx'($urandom_range(31));
        vals[REG_SPARE_HI]      = t_idx'($urandom_range(31));
        i_cfg_we = 1'b1;
        for (int i = 0; i < 8; i++) begin
            i_cfg_index = t_cfg_idx'(i);
            i_cfg_data  = vals[i];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        pools[POOL_FIXED].first   = fx_first;
        pools[POOL_FIXED].last    = fx_last;
        pools[POOL_FIXED].restart = fx_restart;
        pools[POOL_FLOAT].first   = fl_first;
        pools[POOL_FLOAT].last    = fl_last;
        pools[POOL_FLOAT].restart = fl_restart;
    endtask

    // Busy masks biased toward the interesting cases: one free slot,
    // fully busy, sparse free, dense free, plain random.
    function automatic t_mask pick_busy();
        case ($urandom_range(5))
            0:       return t_mask'($urandom);
            1:       return ~(t_mask'(1) << $urandom_range(MaskW - 1));
            2:       return '1;
            3:       return t_mask'($urandom) | t_mask'($urandom);
            4:       return ~(t_mask'($urandom) & t_mask'($urandom) & t_mask'($urandom));
            default: return t_mask'($urandom_range(1)) << $urandom_range(MaskW - 1);
        endcase
    endfunction

    function automatic t_action pick_action();
        int r;
        r = $urandom_range(99);
        if (r < 6)  return ACT_RESTART;
        if (r < 10) return ACT_UNUSED;
        if (r < 55) return ACT_FIXED;
        return ACT_FLOAT;
    endfunction

    task automatic run_random(int n_items, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_items) send_request(pick_action(), pick_busy(), 1'b0, '0, 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Result side: stall decision at the falling edge. A hold request from
    // the stimulus turns into a long counted stall here.
    // ------------------------------------------------------------------
    initial begin : result_side
        int hold_left;
        hold_left   = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    // Every accepted result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_grant want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (grants_due.size() == 0) begin
                flag_mismatch("result with nothing outstanding, slot", int'(o_slot), 0);
            end else begin
                want = grants_due.pop_front();
                n_checked++;
                if (want.granted) n_grants++;
                else n_refusals++;
                if (o_slot !== want.slot)
                    flag_mismatch("slot", int'(o_slot), int'(want.slot));
                if (o_granted !== want.granted)
                    flag_mismatch("granted", int'(o_granted), int'(want.granted));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        mismatches         = 0;
        n_checked          = 0;
        n_grants           = 0;
        n_refusals         = 0;
        n_restarts         = 0;
        hold_req           = 1'b0;
        sender_idle_pct    = RATE_NONE;
        receiver_stall_pct = RATE_NONE;
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_action           = ACT_RESTART;
        i_busy_mask        = '0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = REG_FIXED_FIRST;
        i_cfg_data         = '0;

        pools[POOL_FIXED] = '{first: RST_FIXED_FIRST, last: RST_FIXED_LAST,
                              restart: RST_FIXED_RESTART, ptr: RST_FIXED_RESTART};
        pools[POOL_FLOAT] = '{first: RST_FLOAT_FIRST, last: RST_FLOAT_LAST,
                              restart: RST_FLOAT_RESTART, ptr: RST_FLOAT_RESTART};

        // Reset pointers: fixed 11, float 1, both pools 0..31.
        // typed = 1 rows carry an expectation read straight off the rules.
        directed_rows = '{
            '{ACT_FIXED,   32'h0000_0000, 1'b1, 5'd11, 1'b1},  // from reset pointer
            '{ACT_FLOAT,   32'h0000_0000, 1'b1, 5'd1,  1'b1},
            '{ACT_FIXED,   32'hFFFF_FFFF, 1'b1, 5'd0,  1'b0},  // all busy
            '{ACT_FLOAT,   32'hFFFF_FFFF, 1'b1, 5'd0,  1'b0},
            '{ACT_RESTART, 32'hDEAD_BEEF, 1'b1, 5'd0,  1'b0},  // mask ignored
            '{ACT_UNUSED,  32'h0000_0000, 1'b1, 5'd0,  1'b0},  // ignored code
            '{ACT_FIXED,   32'h0000_0000, 1'b1, 5'd11, 1'b1},  // pointer untouched
            '{ACT_FIXED,   32'hFFFF_FFFE, 1'b1, 5'd0,  1'b1},  // wrap 31 -> 0
            '{ACT_FLOAT,   32'h7FFF_FFFF, 1'b1, 5'd31, 1'b1},  // top slot only
            '{ACT_FLOAT,   32'h0000_0000, 1'b1, 5'd0,  1'b1},  // pointer wrapped
            '{ACT_FIXED,   32'hAAAA_AAAA, 1'b0, 5'd0,  1'b0},
            '{ACT_FLOAT,   32'h5555_5555, 1'b0, 5'd0,  1'b0},
            '{ACT_FIXED,   32'h8000_0000, 1'b0, 5'd0,  1'b0},
            '{ACT_FLOAT,   32'h0000_0001, 1'b0, 5'd0,  1'b0},
            '{ACT_RESTART, 32'h0000_0000, 1'b1, 5'd0,  1'b0},
            '{ACT_FIXED,   32'hFFFF_F7FF, 1'b1, 5'd11, 1'b1},  // only restart slot free
            '{ACT_FLOAT,   32'hFFFF_FFFD, 1'b1, 5'd1,  1'b1},
            '{ACT_FLOAT,   32'h0000_0000, 1'b0, 5'd0,  1'b0},
            '{ACT_FIXED,   32'h0000_FFFF, 1'b0, 5'd0,  1'b0},
            '{ACT_UNUSED,  32'hFFFF_FFFF, 1'b1, 5'd0,  1'b0}
        };

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pass at reset configuration, no idling
        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].busy, directed_rows[i].typed,
                         directed_rows[i].slot, directed_rows[i].granted);

        // Defaults, full throughput
        run_random(100, RATE_NONE, RATE_NONE);
        wait_drained();

        // Full fixed range restarting at 0; float pinned to the top slot
        load_setting(5'd0, 5'd31, 5'd0, 5'd31, 5'd31, 5'd31);
        run_random(140, RATE_HEAVY, RATE_NONE);
        wait_drained();

        // Narrow windows inside the vector
        load_setting(5'd4, 5'd9, 5'd7, 5'd16, 5'd23, 5'd23);
        run_random(140, RATE_NONE, RATE_HEAVY);
        wait_drained();

        // first > last, restart inside the wrapped window
        load_setting(5'd20, 5'd5, 5'd25, 5'd30, 5'd2, 5'd0);
        run_random(140, RATE_BOTH, RATE_BOTH);
        wait_drained();

        // Single-slot pools at both ends. Receiver holds off for a long
        // stretch while requests keep coming, so the block backs up and
        // stalls its input; then the sender waits for a full drain.
        load_setting(5'd31, 5'd31, 5'd31, 5'd0, 5'd0, 5'd0);
        hold_req = 1'b1;
        run_random(60, RATE_NONE, RATE_NONE);
        wait_drained();
        run_random(60, RATE_BOTH, RATE_HEAVY);
        wait_drained();

        // Arbitrary register values, mixed traffic shapes
        for (int k = 0; k < 3; k++) begin
            load_setting(t_idx'($urandom_range(31)), t_idx'($urandom_range(31)),
                         t_idx'($urandom_range(31)), t_idx'($urandom_range(31)),
                         t_idx'($urandom_range(31)), t_idx'($urandom_range(31)));
            run_random(80, (k == 1) ? RATE_HEAVY : RATE_BOTH, (k == 2) ? RATE_HEAVY : RATE_NONE);
            wait_drained();
        end

        // Back to the reset values
        load_setting(RST_FIXED_FIRST, RST_FIXED_LAST, RST_FIXED_RESTART,
                     RST_FLOAT_FIRST, RST_FLOAT_LAST, RST_FLOAT_RESTART);
        run_random(60, RATE_NONE, RATE_NONE);
        wait_drained();
        repeat (5) @(negedge i_clk);

        $display("Checked %0d results: %0d grants, %0d refusals, %0d restarts.",
                 n_checked, n_grants, n_refusals, n_restarts);
        $display("Settings: reset, full, narrow, inverted, single-slot, random; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
